// ----- rtl/lsbc_pkg.sv -----
// shared types and codes for the lru sector buffer cache
`timescale 1ns / 1ps
package lsbc_pkg;

  localparam int unsigned SECTOR_W = 32;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned HANDLE_W = 2;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned RES_W    = 16;
  localparam int unsigned COPIES_W = 8;

  localparam logic [CMD_W-1:0] CMD_LOOKUP    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MARK      = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH_ONE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FLUSH_ALL = 2'd3;

  localparam logic [ACTION_W-1:0] ACT_DONE  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PART_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAT_SECTORS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAT_COPIES = 2'd3;

  localparam logic [COPIES_W-1:0] MIRROR_COPIES = 8'd2;

  // per-buffer update strobes from the sequencer
  typedef struct packed {
    logic wr_tag;
    logic set_dirty;
    logic clr_dirty;
  } buf_ctrl_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_LOOK = 7'b0000010,
    ST_SCAN = 7'b0000100,
    ST_WB   = 7'b0001000,
    ST_MIR  = 7'b0010000,
    ST_RD   = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_e;

endpackage

// ----- rtl/lsbc_buf_cell.sv -----
// one buffer cell: sector tag, dirty bit and a link of the first-match chain
`timescale 1ns / 1ps
module lsbc_buf_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lsbc_pkg::buf_ctrl_t          ctrl_i,
  input  logic [lsbc_pkg::SECTOR_W-1:0] sector_i,
  input  logic                         found_i,
  output logic                         found_o,
  output logic                         win_o,
  output logic [lsbc_pkg::SECTOR_W-1:0] tag_o,
  output logic                         dirty_o
);
  import lsbc_pkg::*;

  logic [SECTOR_W-1:0] tag_q;
  logic                dirty_q;
  logic                match;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q   <= '0;
      dirty_q <= 1'b0;
    end else begin
      if (ctrl_i.wr_tag) begin
        tag_q <= sector_i;
      end
      if (ctrl_i.set_dirty) begin
        dirty_q <= 1'b1;
      end else if (ctrl_i.clr_dirty) begin
        dirty_q <= 1'b0;
      end
    end
  end

  assign match   = (tag_q == sector_i);
  // lowest matching index wins
  assign win_o   = match & ~found_i;
  assign found_o = match | found_i;
  assign tag_o   = tag_q;
  assign dirty_o = dirty_q;

endmodule

// ----- rtl/lsbc_age_cell.sv -----
// one position of the lru age stack, shifting down from its upper neighbor
`timescale 1ns / 1ps
module lsbc_age_cell #(
  parameter int unsigned IDX_W    = 2,
  parameter int unsigned RESET_ID = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             upd_i,
  input  logic [IDX_W-1:0] hit_id_i,
  input  logic [IDX_W-1:0] prev_i,
  input  logic             seen_i,
  output logic             seen_o,
  output logic [IDX_W-1:0] id_o
);
  import lsbc_pkg::*;

  logic [IDX_W-1:0] id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q <= IDX_W'(RESET_ID);
    end else if (upd_i && !seen_i) begin
      // hit buffer not above this position: take the entry from above
      id_q <= prev_i;
    end
  end

  assign seen_o = seen_i | (id_q == hit_id_i);
  assign id_o   = id_q;

endmodule

// ----- rtl/lru_sector_buffer_cache_core.sv -----
// top level of the lru write-back sector buffer cache controller
`timescale 1ns / 1ps
// A command is taken when start is high and busy is low; busy stays high until
// the done report has gone out. Each result (a write, a read or the done report
// with last set) is shown for one cycle with result_valid_o and must be taken
// then. The sequencer emits one result per cycle except in search and scan steps:
// a lookup searches the tag cells, then gives the report on a hit; on a miss, a
// write-back of a dirty victim (and its fat mirror), the read and the report;
// mark dirty gives the report; flush one and flush all write back, then report.
// Busy drops in the cycle after the report. Configuration writes are taken at any
// edge with cfg_we_i and are meant only while the block is idle.
module lru_sector_buffer_cache_core #(
  parameter int unsigned NUM_BUFFERS = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lsbc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [lsbc_pkg::SECTOR_W-1:0]    cfg_data_i,
  input  logic                             start,
  output logic                             busy,
  input  logic [lsbc_pkg::CMD_W-1:0]       command_i,
  input  logic [lsbc_pkg::SECTOR_W-1:0]    sector_i,
  input  logic [lsbc_pkg::HANDLE_W-1:0]    handle_i,
  input  logic                             force_req_i,
  output logic                             result_valid_o,
  output logic [lsbc_pkg::ACTION_W-1:0]    action_o,
  output logic [lsbc_pkg::SECTOR_W-1:0]    target_sector_o,
  output logic [lsbc_pkg::HANDLE_W-1:0]    buffer_index_o,
  output logic                             hit_o,
  output logic                             last_o
);
  import lsbc_pkg::*;

  localparam int unsigned IDX_W = $clog2(NUM_BUFFERS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUFFERS - 1);

  // configuration
  logic [SECTOR_W-1:0] part_start_q;
  logic [RES_W-1:0]    reserved_q;
  logic [SECTOR_W-1:0] fat_sectors_q;
  logic [COPIES_W-1:0] fat_copies_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_start_q  <= '0;
      reserved_q    <= '0;
      fat_sectors_q <= '0;
      fat_copies_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PART_START:  part_start_q  <= cfg_data_i;
        CFG_RESERVED:    reserved_q    <= cfg_data_i[RES_W-1:0];
        CFG_FAT_SECTORS: fat_sectors_q <= cfg_data_i;
        CFG_FAT_COPIES:  fat_copies_q  <= cfg_data_i[COPIES_W-1:0];
        default: ;
      endcase
    end
  end

  // command registers
  state_e              state_q, state_d;
  logic [CMD_W-1:0]    cmd_q;
  logic [SECTOR_W-1:0] sec_q;
  logic [HANDLE_W-1:0] hdl_q;
  logic                force_q;
  logic [IDX_W-1:0]    cur_q, cur_d;
  logic                found_q, found_d;

  // cell row
  buf_ctrl_t           ctrl [NUM_BUFFERS];
  logic [SECTOR_W-1:0] tags [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0] dirty;
  logic [NUM_BUFFERS-1:0] win;
  logic [NUM_BUFFERS:0]   found_chain;
  logic [IDX_W-1:0]    age_id [NUM_BUFFERS];
  logic [NUM_BUFFERS:0]   seen_chain;
  logic                age_upd;

  assign found_chain[0] = 1'b0;
  assign seen_chain[0]  = 1'b0;

  for (genvar g = 0; g < NUM_BUFFERS; g++) begin : g_cells
    lsbc_buf_cell u_buf (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl[g]),
      .sector_i (sec_q),
      .found_i  (found_chain[g]),
      .found_o  (found_chain[g+1]),
      .win_o    (win[g]),
      .tag_o    (tags[g]),
      .dirty_o  (dirty[g])
    );

    lsbc_age_cell #(
      .IDX_W    (IDX_W),
      .RESET_ID (g)
    ) u_age (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .upd_i    (age_upd),
      .hit_id_i (cur_q),
      .prev_i   ((g == 0) ? cur_q : age_id[(g == 0) ? 0 : g-1]),
      .seen_i   (seen_chain[g]),
      .seen_o   (seen_chain[g+1]),
      .id_o     (age_id[g])
    );
  end

  // index of the first matching buffer
  logic [IDX_W-1:0] match_idx;
  always_comb begin
    match_idx = '0;
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      if (win[i]) begin
        match_idx = match_idx | IDX_W'(i);
      end
    end
  end

  // handle decode
  logic [IDX_W+HANDLE_W-1:0] hdl_ext;
  logic                      hdl_ok;
  assign hdl_ext = {{IDX_W{1'b0}}, handle_i};
  assign hdl_ok  = (int'(handle_i) < NUM_BUFFERS);

  // fat mirror check on the current buffer
  logic [SECTOR_W-1:0] cur_tag;
  logic [SECTOR_W-1:0] rel;
  logic [SECTOR_W:0]   fat_hi;
  logic                mirror;
  assign cur_tag = tags[cur_q];
  assign rel     = cur_tag - part_start_q;
  assign fat_hi  = {{(SECTOR_W+1-RES_W){1'b0}}, reserved_q} + {1'b0, fat_sectors_q};
  assign mirror  = (fat_copies_q == MIRROR_COPIES)
                && (rel >= {{(SECTOR_W-RES_W){1'b0}}, reserved_q})
                && ({1'b0, rel} < fat_hi);

  logic cur_last;
  assign cur_last = (cur_q == LAST_IDX);

  // sequencer
  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    found_d = found_q;
    age_upd = 1'b0;
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      ctrl[i] = '0;
    end
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (command_i)
            CMD_LOOKUP: state_d = ST_LOOK;
            CMD_MARK: begin
              for (int i = 0; i < NUM_BUFFERS; i++) begin
                ctrl[i].set_dirty = hdl_ok && (int'(handle_i) == i);
              end
              state_d = ST_DONE;
            end
            CMD_FLUSH_ONE: begin
              cur_d   = hdl_ext[IDX_W-1:0];
              state_d = hdl_ok ? ST_SCAN : ST_DONE;
            end
            default: begin
              cur_d   = '0;
              state_d = ST_SCAN;
            end
          endcase
        end
      end
      ST_LOOK: begin
        found_d = found_chain[NUM_BUFFERS];
        if (found_chain[NUM_BUFFERS]) begin
          cur_d   = match_idx;
          state_d = ST_DONE;
        end else begin
          cur_d   = age_id[NUM_BUFFERS-1];
          state_d = dirty[age_id[NUM_BUFFERS-1]] ? ST_WB : ST_RD;
        end
      end
      ST_SCAN: begin
        if (dirty[cur_q] || (cmd_q == CMD_FLUSH_ONE && force_q)) begin
          state_d = ST_WB;
        end else if (cmd_q == CMD_FLUSH_ALL && !cur_last) begin
          cur_d = cur_q + 1'b1;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_WB, ST_MIR: begin
        if (state_q == ST_WB) begin
          ctrl[cur_q].clr_dirty = 1'b1;
        end
        if (state_q == ST_WB && mirror) begin
          state_d = ST_MIR;
        end else if (cmd_q == CMD_LOOKUP) begin
          state_d = ST_RD;
        end else if (cmd_q == CMD_FLUSH_ALL && !cur_last) begin
          cur_d   = cur_q + 1'b1;
          state_d = ST_SCAN;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_RD: state_d = ST_DONE;
      ST_DONE: begin
        if (cmd_q == CMD_LOOKUP) begin
          ctrl[cur_q].wr_tag = 1'b1;
          age_upd = 1'b1;
        end
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cur_q   <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) begin
      cmd_q   <= command_i;
      sec_q   <= sector_i;
      hdl_q   <= handle_i;
      force_q <= force_req_i;
    end
  end

  // result ports
  logic [IDX_W+HANDLE_W-1:0] cur_ext;
  assign cur_ext = {{HANDLE_W{1'b0}}, cur_q};

  assign busy = (state_q != ST_IDLE);

  always_comb begin
    result_valid_o  = 1'b0;
    action_o        = ACT_DONE;
    target_sector_o = '0;
    buffer_index_o  = cur_ext[HANDLE_W-1:0];
    hit_o           = 1'b0;
    last_o          = 1'b0;
    case (state_q)
      ST_WB: begin
        result_valid_o  = 1'b1;
        action_o        = ACT_WRITE;
        target_sector_o = cur_tag;
      end
      ST_MIR: begin
        result_valid_o  = 1'b1;
        action_o        = ACT_WRITE;
        target_sector_o = cur_tag + fat_sectors_q;
      end
      ST_RD: begin
        result_valid_o  = 1'b1;
        action_o        = ACT_READ;
        target_sector_o = sec_q;
      end
      ST_DONE: begin
        result_valid_o = 1'b1;
        last_o         = 1'b1;
        case (cmd_q)
          CMD_LOOKUP: begin
            target_sector_o = sec_q;
            hit_o           = found_q;
          end
          CMD_FLUSH_ALL: buffer_index_o = '0;
          default:       buffer_index_o = hdl_q;
        endcase
      end
      default: ;
    endcase
  end

endmodule
